// ===== rtl/core/weighted_round_robin_select_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the weighted round robin selector
// Shared implication checks, clocked and disabled under reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_SELECT_TOP_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_SELECT_TOP_MACROS_SVH

// same-cycle implication
`define WRRS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wrrs check failed");

// next-cycle implication
`define WRRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wrrs check failed");

`endif

// ===== rtl/core/wrrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrrs_pkg
// Types and constants shared by the weighted round robin selector.
// ----------------------------------------------------------------------------
package wrrs_pkg;

   localparam int MAX_BACKENDS = 8;
   localparam int MASK_W       = 8;
   localparam int WEIGHT_W     = 8;
   localparam int BACKEND_W    = 3;
   localparam int CSR_IDX_W    = 4;
   localparam int COUNT_WIDTH  = 64;
   localparam int TOT_W        = 11;
   localparam int CTR_W        = $clog2(COUNT_WIDTH);
   localparam int STEP_W       = 3;

   typedef logic [2:0]        op_type;
   typedef logic [2:0]        cond_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [CTR_W-1:0]  ctr_type;

   localparam op_type OP_IDLE  = 3'd0;
   localparam op_type OP_ACCUM = 3'd1;
   localparam op_type OP_SETUP = 3'd2;
   localparam op_type OP_DIV   = 3'd3;
   localparam op_type OP_SCAN  = 3'd4;
   localparam op_type OP_INC   = 3'd5;
   localparam op_type OP_EMIT  = 3'd6;

   localparam cond_type COND_ALWAYS   = 3'd0;
   localparam cond_type COND_REQ      = 3'd1;
   localparam cond_type COND_BE_LAST  = 3'd2;
   localparam cond_type COND_BIT_LAST = 3'd3;
   localparam cond_type COND_ZERO     = 3'd4;
   localparam cond_type COND_HIT      = 3'd5;
   localparam cond_type COND_OUT_FREE = 3'd6;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     hold;
   } ucode_type;

   typedef struct packed {
      op_type  op;
      ctr_type ctr;
   } ctl_type;

   typedef struct packed {
      logic total_zero;
      logic hit;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/wrrs_req_if.sv =====
// ----------------------------------------------------------------------------
// wrrs_req_if
// Request channel: backend availability mask.
// ----------------------------------------------------------------------------
interface wrrs_req_if;
   logic                          valid;
   logic                          ready;
   logic [wrrs_pkg::MASK_W-1:0]   available_mask;

   modport source (output valid, output available_mask, input ready);
   modport sink   (input valid, input available_mask, output ready);
endinterface

// ===== rtl/core/wrrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wrrs_rsp_if
// Response channel: selection result.
// ----------------------------------------------------------------------------
interface wrrs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [wrrs_pkg::BACKEND_W-1:0]  chosen_backend;

   modport source (output valid, output found, output chosen_backend, input ready);
   modport sink   (input valid, input found, input chosen_backend, output ready);
endinterface

// ===== rtl/core/weighted_round_robin_select_top.sv =====
// ----------------------------------------------------------------------------
// weighted_round_robin_select_top
// Weighted round robin backend selector driven by a microcoded sequencer.
//
//   channel | dir | handshake            | payload
//   req     | in  | req.valid/req.ready  | available_mask[7:0]
//   rsp     | out | rsp.valid/rsp.ready  | found, chosen_backend[2:0]
//   csr     | in  | csr_we               | csr_index[3:0], csr_wdata[7:0]
//
// One request at a time: accept, sum over NUM_BACKENDS weights, setup, modulo
// of the 64-bit request counter (one counter bit per cycle), scan of up to
// NUM_BACKENDS slots, increment, emit; with no backend available, setup goes to emit.
// Reset is synchronous; no clearing pass. A stalled response stays in its
// register while the next request is taken and worked on.
// ----------------------------------------------------------------------------
module weighted_round_robin_select_top #(
   parameter int NUM_BACKENDS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   wrrs_req_if.sink                        req,
   wrrs_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [wrrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrrs_pkg::WEIGHT_W-1:0]   csr_wdata
);
   import wrrs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   wrrs_sequencer #(
      .NUM_BACKENDS (NUM_BACKENDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   wrrs_datapath #(
      .NUM_BACKENDS (NUM_BACKENDS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .req_mask   (req.available_mask),
      .rsp_ready  (rsp.ready),
      .sts        (sts),
      .rsp_valid  (rsp.valid),
      .rsp_found  (rsp.found),
      .rsp_chosen (rsp.chosen_backend)
   );

   assign req.ready = (ctl.op == OP_IDLE);

endmodule

// ===== rtl/core/wrrs_sequencer.sv =====
// ----------------------------------------------------------------------------
// wrrs_sequencer
// Microcode store, step counter, loop counter and jump condition logic.
// ----------------------------------------------------------------------------
module wrrs_sequencer #(
   parameter int NUM_BACKENDS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  wrrs_pkg::sts_type sts,
   output wrrs_pkg::ctl_type ctl
);
   import wrrs_pkg::*;

   localparam step_type S_IDLE  = 3'd0;
   localparam step_type S_ACCUM = 3'd1;
   localparam step_type S_SETUP = 3'd2;
   localparam step_type S_DIV   = 3'd3;
   localparam step_type S_SCAN  = 3'd4;
   localparam step_type S_INC   = 3'd5;
   localparam step_type S_EMIT  = 3'd6;

   localparam ctr_type BE_LAST  = CTR_W'(NUM_BACKENDS - 1);
   localparam ctr_type BIT_LAST = CTR_W'(COUNT_WIDTH - 1);

   step_type  step_ff, step_in;
   ctr_type   ctr_ff, ctr_in;
   ucode_type uw;
   logic      met;

   // control store
   always_comb begin
      unique case (step_ff)
         S_IDLE:  uw = '{op: OP_IDLE,  cond: COND_REQ,      target: S_ACCUM, hold: 1'b1};
         S_ACCUM: uw = '{op: OP_ACCUM, cond: COND_BE_LAST,  target: S_SETUP, hold: 1'b1};
         S_SETUP: uw = '{op: OP_SETUP, cond: COND_ZERO,     target: S_EMIT,  hold: 1'b0};
         S_DIV:   uw = '{op: OP_DIV,   cond: COND_BIT_LAST, target: S_SCAN,  hold: 1'b1};
         S_SCAN:  uw = '{op: OP_SCAN,  cond: COND_HIT,      target: S_INC,   hold: 1'b1};
         S_INC:   uw = '{op: OP_INC,   cond: COND_ALWAYS,   target: S_EMIT,  hold: 1'b1};
         S_EMIT:  uw = '{op: OP_EMIT,  cond: COND_OUT_FREE, target: S_IDLE,  hold: 1'b1};
         default: uw = '{op: OP_IDLE,  cond: COND_ALWAYS,   target: S_IDLE,  hold: 1'b1};
      endcase
   end

   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:   met = 1'b1;
         COND_REQ:      met = req_valid;
         COND_BE_LAST:  met = (ctr_ff == BE_LAST);
         COND_BIT_LAST: met = (ctr_ff == BIT_LAST);
         COND_ZERO:     met = sts.total_zero;
         COND_HIT:      met = sts.hit || (ctr_ff == BE_LAST);
         COND_OUT_FREE: met = sts.out_free;
         default:       met = 1'b1;
      endcase
   end

   always_comb begin
      if (met) begin
         step_in = uw.target;
      end else if (uw.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + step_type'(1);
      end
      ctr_in = (met || !uw.hold) ? '0 : ctr_ff + ctr_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
         ctr_ff  <= '0;
      end else begin
         step_ff <= step_in;
         ctr_ff  <= ctr_in;
      end
   end

   assign ctl = '{op: uw.op, ctr: ctr_ff};

endmodule

// ===== rtl/core/wrrs_datapath.sv =====
// ----------------------------------------------------------------------------
// wrrs_datapath
// Weight registers, request counter, slot accumulator, serial modulo
// and slot scan, plus the response register.
// ----------------------------------------------------------------------------
`include "weighted_round_robin_select_top_macros.svh"

module wrrs_datapath #(
   parameter int NUM_BACKENDS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [wrrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wrrs_pkg::WEIGHT_W-1:0]     csr_wdata,
   input  wrrs_pkg::ctl_type                 ctl,
   input  logic [wrrs_pkg::MASK_W-1:0]       req_mask,
   input  logic                              rsp_ready,
   output wrrs_pkg::sts_type                 sts,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [wrrs_pkg::BACKEND_W-1:0]    rsp_chosen
);
   import wrrs_pkg::*;

   localparam int IDX_W = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   logic [WEIGHT_W-1:0]     weight_ff [NUM_BACKENDS];
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [NUM_BACKENDS-1:0] mask_ff, mask_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [TOT_W-1:0]        rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [IDX_W-1:0]        chosen_ff, chosen_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [BACKEND_W-1:0]    rsp_chosen_ff, rsp_chosen_in;

   logic [IDX_W-1:0]        idx;
   logic [WEIGHT_W-1:0]     w_raw, w_eff;
   logic                    usable, hit, out_free, total_zero, ge;
   logic [TOT_W:0]          rem_sh, rem_diff;

   assign idx        = ctl.ctr[IDX_W-1:0];
   assign w_raw      = weight_ff[idx];
   assign w_eff      = (w_raw == '0) ? WEIGHT_W'(1) : w_raw;
   assign usable     = mask_ff[idx];
   assign hit        = usable && (rem_ff < TOT_W'(w_eff));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign total_zero = (total_ff == '0);
   assign rem_sh     = {rem_ff, dvd_ff[COUNT_WIDTH-1]};
   assign ge         = (rem_sh >= {1'b0, total_ff});
   assign rem_diff   = rem_sh - {1'b0, total_ff};

   always_comb begin
      count_in      = count_ff;
      mask_in       = mask_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      chosen_in     = chosen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      found_in      = found_ff;
      rsp_chosen_in = rsp_chosen_ff;
      unique case (ctl.op)
         OP_IDLE: begin
            mask_in  = req_mask[NUM_BACKENDS-1:0];
            total_in = '0;
         end
         OP_ACCUM: begin
            if (usable) begin
               total_in = total_ff + TOT_W'(w_eff);
            end
         end
         OP_SETUP: begin
            rem_in = '0;
            dvd_in = count_ff;
         end
         OP_DIV: begin
            rem_in = ge ? rem_diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            dvd_in = {dvd_ff[COUNT_WIDTH-2:0], 1'b0};
         end
         OP_SCAN: begin
            if (hit) begin
               chosen_in = idx;
            end else if (usable) begin
               rem_in = rem_ff - TOT_W'(w_eff);
            end
         end
         OP_INC: begin
            count_in = count_ff + CNT_ONE;
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               found_in      = !total_zero;
               rsp_chosen_in = total_zero ? '0 : BACKEND_W'(chosen_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BACKENDS; i++) begin
            weight_ff[i] <= WEIGHT_W'(1);
         end
      end else if (csr_we && (csr_index < CSR_IDX_W'(NUM_BACKENDS))) begin
         weight_ff[csr_index[IDX_W-1:0]] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      total_ff      <= total_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      chosen_ff     <= chosen_in;
      found_ff      <= found_in;
      rsp_chosen_ff <= rsp_chosen_in;
   end

   assign sts        = '{total_zero: total_zero, hit: hit, out_free: out_free};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = found_ff;
   assign rsp_chosen = rsp_chosen_ff;

   `WRRS_ASSERT_NOW(a_div_nonzero, clock, reset, ctl.op == OP_DIV, !total_zero)
   `WRRS_ASSERT_NOW(a_slot_in_range, clock, reset, ctl.op == OP_SCAN, rem_ff < total_ff)
   `WRRS_ASSERT_NEXT(a_count_step, clock, reset, ctl.op == OP_INC, count_ff == $past(count_ff) + CNT_ONE)
   `WRRS_ASSERT_NOW(a_none_zero, clock, reset, rsp_valid_ff && !found_ff, rsp_chosen_ff == '0)

endmodule
